>>> src/pcea_pkg.sv
// Shared types and constants for the pack cell extreme aggregator.
// Used by the front, queue, back and top level; depends on nothing.
`timescale 1ns / 1ps

package pcea_pkg;

  localparam int PACKS_DEFAULT = 18;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [21:0] CODE_VOLT = 22'h18FF36;
  localparam logic [21:0] CODE_TEMP = 22'h18FF4B;

  localparam int IN_DATA_W = 96;
  localparam int OUT_DATA_W = 96;
  localparam int ID_W = 29;
  localparam int QUOT_W = 8;

  typedef enum logic [1:0] {
    OP_VOLT = 2'd0,
    OP_TEMP = 2'd1,
    OP_EVAL = 2'd2
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       pack;
    logic [7:0][7:0]  bytes;
  } cmd_t;

endpackage

>>> src/pcea_front.sv
// Front end: accepts input transactions, decodes pack number and message code.
// Drops frames that change nothing; depends on pcea_pkg.
`timescale 1ns / 1ps

module pcea_front #(
  parameter int PACKS = pcea_pkg::PACKS_DEFAULT
) (
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [pcea_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  logic                           q_full,
  output logic                           q_push,
  output pcea_pkg::cmd_t                 q_cmd
);

  logic [7:0]  pack_raw;
  logic [7:0]  pack_dec;
  logic [21:0] code;
  logic        in_range;
  logic        is_volt;
  logic        is_temp;
  logic        keep;

  always_comb begin
    pack_raw = in_tdata[7:0];
    pack_dec = (pack_raw != 8'd0) ? pack_raw - 8'd1 : 8'd0;
    code     = {1'b0, in_tdata[pcea_pkg::ID_W-1:8]};
    in_range = pack_dec < 8'(PACKS);
    is_volt  = code == pcea_pkg::CODE_VOLT;
    is_temp  = code == pcea_pkg::CODE_TEMP;
    keep     = in_tuser || (in_range && (is_volt || is_temp));

    q_cmd.pack = pack_dec;
    for (int k = 0; k < 8; k++) begin
      q_cmd.bytes[k] = in_tdata[pcea_pkg::ID_W + 8*k +: 8];
    end
    if (in_tuser) begin
      q_cmd.op = pcea_pkg::OP_EVAL;
    end else if (is_volt) begin
      q_cmd.op = pcea_pkg::OP_VOLT;
    end else begin
      q_cmd.op = pcea_pkg::OP_TEMP;
    end
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready && keep;

endmodule

>>> src/pcea_queue.sv
// Short command queue between the front end and the back end.
// Register based ring buffer of decoded commands; depends on pcea_pkg.
`timescale 1ns / 1ps

module pcea_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pcea_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output pcea_pkg::cmd_t head
);

  localparam int PTR_W = (pcea_pkg::QUEUE_DEPTH > 1) ? $clog2(pcea_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(pcea_pkg::QUEUE_DEPTH + 1);

  pcea_pkg::cmd_t   mem_r [pcea_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = cnt_r == CNT_W'(pcea_pkg::QUEUE_DEPTH);
  assign empty   = cnt_r == '0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(pcea_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(pcea_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> src/pcea_back.sv
// Back end: per-pack extreme storage, evaluation scan, trimmed average divider.
// Holds the result register for the output channel; depends on pcea_pkg.
`timescale 1ns / 1ps

module pcea_back #(
  parameter int PACKS = pcea_pkg::PACKS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_empty,
  input  pcea_pkg::cmd_t                  q_head,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pcea_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W     = $clog2(PACKS);
  localparam int SUM_W     = $clog2(PACKS * 510 + 1);
  localparam int DIVISOR   = 2 * PACKS - 2;
  localparam int REC_SHIFT = SUM_W + $clog2(DIVISOR);
  localparam int RECIP     = ((1 << REC_SHIFT) + DIVISOR - 1) / DIVISOR;
  localparam int PROD_W    = REC_SHIFT + pcea_pkg::QUOT_W;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_TRIM = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] vmax_r [PACKS];
  logic [15:0] vmin_r [PACKS];
  logic [7:0]  vmax_cell_r [PACKS];
  logic [7:0]  vmin_cell_r [PACKS];
  logic [7:0]  tmax_r [PACKS];
  logic [7:0]  tmin_r [PACKS];
  logic [7:0]  tmax_cell_r [PACKS];
  logic [7:0]  tmin_cell_r [PACKS];

  logic [IDX_W-1:0]            idx_r;
  logic [15:0]                 vhi_r, vlo_r;
  logic [7:0]                  vhi_c_r, vlo_c_r;
  logic [7:0]                  thi_r, tlo_r, thi_c_r, tlo_c_r;
  logic [SUM_W-1:0]            sum_r;
  logic [SUM_W-1:0]            rem_r;
  logic [pcea_pkg::QUOT_W-1:0] quot_r;
  logic [pcea_pkg::OUT_DATA_W-1:0] out_data_r;
  logic                        out_valid_r;

  logic [IDX_W-1:0]  wr_idx;
  logic              take_cmd;
  logic              scan_last;
  logic              out_free;
  logic [PROD_W-1:0] prod;

  assign wr_idx    = q_head.pack[IDX_W-1:0];
  assign take_cmd  = (state_r == ST_IDLE) && !q_empty;
  assign q_pop     = take_cmd;
  assign scan_last = idx_r == IDX_W'(PACKS - 1);
  assign out_free  = !out_valid_r || out_tready;
  assign prod      = PROD_W'(rem_r) * PROD_W'(RECIP);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take_cmd && q_head.op == pcea_pkg::OP_EVAL) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_nxt = ST_TRIM;
        end
      end
      ST_TRIM: state_nxt = ST_DIV;
      ST_DIV:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PACKS; p++) begin
        vmax_r[p]      <= '0;
        vmin_r[p]      <= '0;
        vmax_cell_r[p] <= '0;
        vmin_cell_r[p] <= '0;
        tmax_r[p]      <= '0;
        tmin_r[p]      <= '0;
        tmax_cell_r[p] <= '0;
        tmin_cell_r[p] <= '0;
      end
    end else if (take_cmd) begin
      if (q_head.op == pcea_pkg::OP_VOLT) begin
        vmax_r[wr_idx]      <= {q_head.bytes[2], q_head.bytes[3]};
        vmin_r[wr_idx]      <= {q_head.bytes[4], q_head.bytes[5]};
        vmax_cell_r[wr_idx] <= q_head.bytes[6];
        vmin_cell_r[wr_idx] <= q_head.bytes[7];
      end else if (q_head.op == pcea_pkg::OP_TEMP) begin
        tmax_r[wr_idx]      <= q_head.bytes[0];
        tmin_r[wr_idx]      <= q_head.bytes[1];
        tmax_cell_r[wr_idx] <= q_head.bytes[2];
        tmin_cell_r[wr_idx] <= q_head.bytes[3];
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        idx_r <= '0;
      end
      ST_SCAN: begin
        idx_r <= idx_r + 1'b1;
        if (idx_r == '0) begin
          vhi_r   <= vmax_r[idx_r];
          vhi_c_r <= vmax_cell_r[idx_r];
          vlo_r   <= vmin_r[idx_r];
          vlo_c_r <= vmin_cell_r[idx_r];
          thi_r   <= tmax_r[idx_r];
          thi_c_r <= tmax_cell_r[idx_r];
          tlo_r   <= tmin_r[idx_r];
          tlo_c_r <= tmin_cell_r[idx_r];
          sum_r   <= SUM_W'(tmax_r[idx_r]) + SUM_W'(tmin_r[idx_r]);
        end else begin
          if (vmax_r[idx_r] >= vhi_r) begin
            vhi_r   <= vmax_r[idx_r];
            vhi_c_r <= vmax_cell_r[idx_r];
          end
          if (vmin_r[idx_r] <= vlo_r) begin
            vlo_r   <= vmin_r[idx_r];
            vlo_c_r <= vmin_cell_r[idx_r];
          end
          if (tmax_r[idx_r] >= thi_r) begin
            thi_r   <= tmax_r[idx_r];
            thi_c_r <= tmax_cell_r[idx_r];
          end
          if (tmin_r[idx_r] <= tlo_r) begin
            tlo_r   <= tmin_r[idx_r];
            tlo_c_r <= tmin_cell_r[idx_r];
          end
          sum_r <= sum_r + SUM_W'(tmax_r[idx_r]) + SUM_W'(tmin_r[idx_r]);
        end
      end
      ST_TRIM: begin
        rem_r <= sum_r - SUM_W'(thi_r) - SUM_W'(tlo_r);
      end
      ST_DIV: begin
        quot_r <= prod[PROD_W-1 -: pcea_pkg::QUOT_W];
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_r <= {7'd0, (vlo_r != 16'd0) && (tlo_r != 8'd0), quot_r,
                         tlo_c_r, tlo_r, thi_c_r, thi_r,
                         vlo_c_r, vlo_r, vhi_c_r, vhi_r};
        end
      end
      default: begin
        idx_r <= '0;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> src/pack_cell_extreme_aggregator_top.sv
// Top level of the pack cell extreme aggregator.
// Instantiates pcea_front, pcea_queue and pcea_back; depends on pcea_pkg.
//
//   Channel  Direction  Handshake            Payload
//   in_      slave      in_tvalid/tready     in_tdata 96 bits, in_tuser = kind
//   out_     master     out_tvalid/tready    out_tdata 96 bits, one per evaluate
//
// A frame transaction updates its pack entry in the back end as it leaves the queue.
// An evaluate transaction is taken from the queue, then passes a scan over the entry
// registers pack by pack, a trim, a reciprocal multiply and a load of the result
// register, which waits while the output register holds a result not yet taken.
// Reset clears all pack entries to zero at once.
// A two entry command queue lets inputs be taken while the back end is busy,
// and the output register holds a result while out_tready is low.
`timescale 1ns / 1ps

module pack_cell_extreme_aggregator_top #(
  parameter int PACKS = pcea_pkg::PACKS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // frame_id, data_byte0 .. data_byte7, zero pad
  input  logic [pcea_pkg::IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // high_voltage, high_voltage_cell, low_voltage, low_voltage_cell, high_temp,
  // high_temp_cell, low_temp, low_temp_cell, avg_temp, ready_res, zero pad
  output logic [pcea_pkg::OUT_DATA_W-1:0] out_tdata
);

  pcea_pkg::cmd_t push_cmd;
  pcea_pkg::cmd_t head;
  logic           push;
  logic           pop;
  logic           full;
  logic           empty;

  pcea_front #(
    .PACKS(PACKS)
  ) u_front (
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .q_full   (full),
    .q_push   (push),
    .q_cmd    (push_cmd)
  );

  pcea_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .full    (full),
    .empty   (empty),
    .head    (head)
  );

  pcea_back #(
    .PACKS(PACKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (empty),
    .q_head    (head),
    .q_pop     (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

>>> tb/pack_cell_extreme_aggregator_top_test.sv
// Self-checking testbench for pack_cell_extreme_aggregator_top: a directed table and then
// random frame and evaluate transactions, checked against a local model of the pack registers.
// Depends on pcea_pkg and the aggregator RTL only.
`timescale 1ns / 1ps

module pack_cell_extreme_aggregator_top_test;

  localparam int PACKS = pcea_pkg::PACKS_DEFAULT;
  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam bit KIND_FRAME = 1'b0;
  localparam bit KIND_EVAL = 1'b1;

  typedef struct packed {
    logic [2:0]      pad;
    logic [7:0][7:0] payload;
    logic [28:0]     frame_id;
  } frame_item_t;

  typedef struct packed {
    logic [6:0]  pad;
    logic        ready_res;
    logic [7:0]  avg_temp;
    logic [7:0]  low_temp_cell;
    logic [7:0]  low_temp;
    logic [7:0]  high_temp_cell;
    logic [7:0]  high_temp;
    logic [7:0]  low_voltage_cell;
    logic [15:0] low_voltage;
    logic [7:0]  high_voltage_cell;
    logic [15:0] high_voltage;
  } extremes_t;

  typedef struct {
    bit          kind;
    frame_item_t item;
    bit          typed;
    extremes_t   result;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [pcea_pkg::IN_DATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [pcea_pkg::OUT_DATA_W-1:0] out_tdata;

  logic [15:0] volt_hi [PACKS];
  logic [15:0] volt_lo [PACKS];
  logic [7:0]  volt_hi_cell [PACKS];
  logic [7:0]  volt_lo_cell [PACKS];
  logic [7:0]  temp_hi [PACKS];
  logic [7:0]  temp_lo [PACKS];
  logic [7:0]  temp_hi_cell [PACKS];
  logic [7:0]  temp_lo_cell [PACKS];

  extremes_t pending_extremes[$];
  int errors = 0;
  int frames_sent = 0;
  int evals_sent = 0;
  int results_checked = 0;
  int ready_results = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit steady_phase = 1'b0;

  pack_cell_extreme_aggregator_top #(
    .PACKS(PACKS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  function automatic logic [28:0] build_id(logic [21:0] code, logic [7:0] pack_sel);
    return {code[20:0], pack_sel};
  endfunction

  function automatic frame_item_t volt_item(logic [7:0] pack_sel, logic [15:0] vhi,
                                            logic [15:0] vlo, logic [7:0] chi,
                                            logic [7:0] clo);
    frame_item_t it;
    it = '0;
    it.frame_id = build_id(pcea_pkg::CODE_VOLT, pack_sel);
    it.payload[0] = $urandom;
    it.payload[1] = $urandom;
    it.payload[2] = vhi[15:8];
    it.payload[3] = vhi[7:0];
    it.payload[4] = vlo[15:8];
    it.payload[5] = vlo[7:0];
    it.payload[6] = chi;
    it.payload[7] = clo;
    return it;
  endfunction

  function automatic frame_item_t temp_item(logic [7:0] pack_sel, logic [7:0] thi,
                                            logic [7:0] tlo, logic [7:0] chi,
                                            logic [7:0] clo);
    frame_item_t it;
    it = '0;
    it.frame_id = build_id(pcea_pkg::CODE_TEMP, pack_sel);
    it.payload = {$urandom, $urandom};
    it.payload[0] = thi;
    it.payload[1] = tlo;
    it.payload[2] = chi;
    it.payload[3] = clo;
    return it;
  endfunction

  function automatic frame_item_t raw_item(logic [28:0] id, logic [63:0] bytes);
    frame_item_t it;
    it = '0;
    it.frame_id = id;
    it.payload = bytes;
    return it;
  endfunction

  function automatic void record_frame(frame_item_t it);
    int pack_no;
    logic [21:0] code;
    pack_no = it.frame_id[7:0];
    code = {1'b0, it.frame_id[28:8]};
    if (pack_no != 0) pack_no--;
    if (pack_no >= PACKS) return;
    if (code == pcea_pkg::CODE_VOLT) begin
      volt_hi[pack_no] = {it.payload[2], it.payload[3]};
      volt_lo[pack_no] = {it.payload[4], it.payload[5]};
      volt_hi_cell[pack_no] = it.payload[6];
      volt_lo_cell[pack_no] = it.payload[7];
    end else if (code == pcea_pkg::CODE_TEMP) begin
      temp_hi[pack_no] = it.payload[0];
      temp_lo[pack_no] = it.payload[1];
      temp_hi_cell[pack_no] = it.payload[2];
      temp_lo_cell[pack_no] = it.payload[3];
    end
  endfunction

  // Later packs win ties, so every comparison includes equality.
  function automatic extremes_t scan_extremes();
    extremes_t r;
    int unsigned sum;
    r = '0;
    sum = 0;
    r.high_voltage = volt_hi[0];
    r.high_voltage_cell = volt_hi_cell[0];
    r.low_voltage = volt_lo[0];
    r.low_voltage_cell = volt_lo_cell[0];
    r.high_temp = temp_hi[0];
    r.high_temp_cell = temp_hi_cell[0];
    r.low_temp = temp_lo[0];
    r.low_temp_cell = temp_lo_cell[0];
    for (int p = 0; p < PACKS; p++) begin
      if (volt_hi[p] >= r.high_voltage) begin
        r.high_voltage = volt_hi[p];
        r.high_voltage_cell = volt_hi_cell[p];
      end
      if (volt_lo[p] <= r.low_voltage) begin
        r.low_voltage = volt_lo[p];
        r.low_voltage_cell = volt_lo_cell[p];
      end
      if (temp_hi[p] >= r.high_temp) begin
        r.high_temp = temp_hi[p];
        r.high_temp_cell = temp_hi_cell[p];
      end
      if (temp_lo[p] <= r.low_temp) begin
        r.low_temp = temp_lo[p];
        r.low_temp_cell = temp_lo_cell[p];
      end
      sum = sum + temp_hi[p] + temp_lo[p];
    end
    sum = sum - r.high_temp - r.low_temp;
    r.avg_temp = 8'(sum / (2 * PACKS - 2));
    r.ready_res = (r.low_voltage != 0) && (r.low_temp != 0);
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_phase || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic logic [15:0] pick_voltage();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 16'h0000;
    if (r < 14) return 16'hFFFF;
    if (r < 40) return 16'(16'h0F00 + $urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  function automatic logic [7:0] pick_temp();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 8'h00;
    if (r < 14) return 8'hFF;
    if (r < 40) return 8'(8'd60 + $urandom_range(0, 3));
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] pick_pack();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'($urandom_range(0, PACKS));
    if (r < 95) return 8'($urandom_range(PACKS + 1, PACKS + 3));
    return 8'($urandom);
  endfunction

  task automatic push_item(input bit kind, input frame_item_t it, input bit typed,
                           input extremes_t typed_result);
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= it;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == KIND_EVAL) begin
      pending_extremes.push_back(typed ? typed_result : scan_extremes());
      evals_sent++;
    end else begin
      record_frame(it);
      frames_sent++;
    end
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic check_result(input extremes_t want, input extremes_t got);
    if (got.high_voltage !== want.high_voltage) begin
      $error("high_voltage: expected %0h, got %0h", want.high_voltage, got.high_voltage);
      errors++;
    end
    if (got.high_voltage_cell !== want.high_voltage_cell) begin
      $error("high_voltage_cell: expected %0h, got %0h", want.high_voltage_cell,
             got.high_voltage_cell);
      errors++;
    end
    if (got.low_voltage !== want.low_voltage) begin
      $error("low_voltage: expected %0h, got %0h", want.low_voltage, got.low_voltage);
      errors++;
    end
    if (got.low_voltage_cell !== want.low_voltage_cell) begin
      $error("low_voltage_cell: expected %0h, got %0h", want.low_voltage_cell,
             got.low_voltage_cell);
      errors++;
    end
    if (got.high_temp !== want.high_temp) begin
      $error("high_temp: expected %0h, got %0h", want.high_temp, got.high_temp);
      errors++;
    end
    if (got.high_temp_cell !== want.high_temp_cell) begin
      $error("high_temp_cell: expected %0h, got %0h", want.high_temp_cell,
             got.high_temp_cell);
      errors++;
    end
    if (got.low_temp !== want.low_temp) begin
      $error("low_temp: expected %0h, got %0h", want.low_temp, got.low_temp);
      errors++;
    end
    if (got.low_temp_cell !== want.low_temp_cell) begin
      $error("low_temp_cell: expected %0h, got %0h", want.low_temp_cell, got.low_temp_cell);
      errors++;
    end
    if (got.avg_temp !== want.avg_temp) begin
      $error("avg_temp: expected %0h, got %0h", want.avg_temp, got.avg_temp);
      errors++;
    end
    if (got.ready_res !== want.ready_res) begin
      $error("ready_res: expected %0h, got %0h", want.ready_res, got.ready_res);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_extremes.size() == 0) begin
        $error("unexpected result transaction: %h", out_tdata);
        errors++;
      end else begin
        check_result(pending_extremes.pop_front(), extremes_t'(out_tdata));
        results_checked++;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d results still expected.", pending_extremes.size());
      $display("** pack_cell_extreme_aggregator_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tdata[88])
      ready_results++;
  end

  initial begin
    script_row_t script[$];
    frame_item_t it;
    int unsigned r;
    logic [21:0] code;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = KIND_FRAME;
    for (int p = 0; p < PACKS; p++) begin
      volt_hi[p] = '0;
      volt_lo[p] = '0;
      volt_hi_cell[p] = '0;
      volt_lo_cell[p] = '0;
      temp_hi[p] = '0;
      temp_lo[p] = '0;
      temp_hi_cell[p] = '0;
      temp_lo_cell[p] = '0;
    end

    // All packs read zero after reset, so the first evaluation is all zero and not ready.
    script.push_back('{KIND_EVAL, raw_item('0, '0), 1'b1, '0});
    script.push_back('{KIND_FRAME, volt_item(8'd0, 16'hFFFF, 16'h0001, 8'h11, 8'h22),
                       1'b0, '0});
    script.push_back('{KIND_EVAL, raw_item('0, '0), 1'b0, '0});
    script.push_back('{KIND_FRAME, volt_item(8'd1, 16'h8000, 16'h0000, 8'h33, 8'h44),
                       1'b0, '0});
    script.push_back('{KIND_EVAL, raw_item('0, '0), 1'b0, '0});
    script.push_back('{KIND_FRAME, volt_item(8'(PACKS), 16'hFFFF, 16'hFFFF, 8'hAA, 8'h55),
                       1'b0, '0});
    script.push_back('{KIND_FRAME, volt_item(8'(PACKS), 16'h8000, 16'hFFFF, 8'hA5, 8'h5A),
                       1'b0, '0});
    script.push_back('{KIND_FRAME, volt_item(8'(PACKS + 1), 16'hFFFF, 16'h0001, 8'hEE,
                       8'hDD), 1'b0, '0});
    script.push_back('{KIND_FRAME, volt_item(8'hFF, 16'hFFFF, 16'h0001, 8'hEE, 8'hDD),
                       1'b0, '0});
    script.push_back('{KIND_FRAME, temp_item(8'd0, 8'hFF, 8'h01, 8'h0F, 8'hF0), 1'b0, '0});
    script.push_back('{KIND_FRAME, temp_item(8'(PACKS), 8'hFF, 8'hFF, 8'h77, 8'h88),
                       1'b0, '0});
    script.push_back('{KIND_FRAME, temp_item(8'd9, 8'h00, 8'h01, 8'h99, 8'h66), 1'b0, '0});
    script.push_back('{KIND_EVAL, raw_item('0, '0), 1'b0, '0});
    script.push_back('{KIND_FRAME, raw_item(29'h1FFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF), 1'b0, '0});
    script.push_back('{KIND_FRAME, raw_item(build_id(pcea_pkg::CODE_VOLT ^ 22'h1, 8'd3),
                       64'h0102_0304_0506_0708), 1'b0, '0});
    script.push_back('{KIND_FRAME, raw_item(build_id(pcea_pkg::CODE_TEMP ^ 22'h100000, 8'd3),
                       64'h0102_0304_0506_0708), 1'b0, '0});
    script.push_back('{KIND_FRAME, raw_item(29'h0, 64'h0), 1'b0, '0});
    script.push_back('{KIND_FRAME, volt_item(8'd6, 16'h0001, 16'h0001, 8'h01, 8'h02),
                       1'b0, '0});
    script.push_back('{KIND_FRAME, temp_item(8'd6, 8'h01, 8'h00, 8'h03, 8'h04), 1'b0, '0});
    script.push_back('{KIND_EVAL, raw_item(29'h1FFFFFFF, 64'hFFFF_FFFF_FFFF_FFFF),
                       1'b0, '0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      push_item(script[i].kind, script[i].item, script[i].typed, script[i].result);
      hold_off(pick_gap());
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) steady_phase = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) begin
        in_tvalid <= 1'b0;
        while (pending_extremes.size() != 0) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      if (r < 38) begin
        it = volt_item(pick_pack(), pick_voltage(), pick_voltage(), 8'($urandom),
                       8'($urandom));
        push_item(KIND_FRAME, it, 1'b0, '0);
      end else if (r < 72) begin
        it = temp_item(pick_pack(), pick_temp(), pick_temp(), 8'($urandom), 8'($urandom));
        push_item(KIND_FRAME, it, 1'b0, '0);
      end else if (r < 80) begin
        it = raw_item(29'($urandom), {$urandom, $urandom});
        push_item(KIND_FRAME, it, 1'b0, '0);
      end else if (r < 85) begin
        code = ($urandom_range(0, 1) == 0) ? pcea_pkg::CODE_VOLT : pcea_pkg::CODE_TEMP;
        code = code ^ (22'h1 << $urandom_range(0, 20));
        it = raw_item(build_id(code, pick_pack()), {$urandom, $urandom});
        push_item(KIND_FRAME, it, 1'b0, '0);
      end else begin
        it = raw_item(29'($urandom), {$urandom, $urandom});
        push_item(KIND_EVAL, it, 1'b0, '0);
      end
      hold_off(pick_gap());
    end

    in_tvalid <= 1'b0;
    while (pending_extremes.size() != 0) @(posedge clk);
    repeat (PACKS + 30) @(posedge clk);

    $display("Sent %0d frame and %0d evaluate transactions over %0d packs.", frames_sent,
             evals_sent, PACKS);
    $display("Checked %0d results, %0d of them with the ready flag set.", results_checked,
             ready_results);
    if (errors == 0)
      $display("** pack_cell_extreme_aggregator_top: PASSED **");
    else
      $display("** pack_cell_extreme_aggregator_top: FAILED **");
    $finish;
  end

endmodule

>>> pack_cell_extreme_aggregator_top.f
src/pcea_pkg.sv
src/pcea_front.sv
src/pcea_queue.sv
src/pcea_back.sv
src/pack_cell_extreme_aggregator_top.sv
tb/pack_cell_extreme_aggregator_top_test.sv
